FILE: src/i2ctqd_pkg.sv
// Shared types, codes and control structs of the I2C transfer queue dispatcher.
package i2ctqd_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;

	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_ISSUE  = 2'd1;
	localparam logic [1:0] KIND_REPORT = 2'd2;

	localparam logic [1:0] ACK_OK   = 2'd0;
	localparam logic [1:0] ACK_OFF  = 2'd1;
	localparam logic [1:0] ACK_BAD  = 2'd2;
	localparam logic [1:0] ACK_FULL = 2'd3;

	localparam logic [1:0] RPT_DONE  = 2'd0;
	localparam logic [1:0] RPT_ERROR = 2'd1;

	localparam logic [1:0] ISSUE_STATUS = 2'd0;

	localparam logic MODE_SUBMIT = 1'b0;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_WRITING   = 2'd1,
		PH_RECEIVING = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SUB_ISSUE,
		ST_SUB_ACK,
		ST_EVT_REPORT,
		ST_EVT_READ,
		ST_EVT_ISSUE
	} state_t;

	typedef struct packed {
		logic [6:0]  addr;
		logic [7:0]  count;
		logic        rd;
		logic [15:0] handle;
		logic [7:0]  tag;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic push;
		logic pop;
		logic ld_issue_in;
		logic ld_issue_mem;
		logic ld_ack;
		logic ld_report;
	} cmd_t;

	typedef struct packed {
		logic is_event;
		logic sub_ok;
		logic issue_now;
		logic evt_hit;
		logic more;
		logic out_free;
	} sts_t;

endpackage

FILE: src/i2ctqd_ctrl.sv
// Controller state machine that sequences accept, queue updates and result loads.
module i2ctqd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  i2ctqd_pkg::sts_t   sts,
	output i2ctqd_pkg::cmd_t   cmd
);

	i2ctqd_pkg::state_t state_q;
	i2ctqd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2ctqd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			i2ctqd_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = i2ctqd_pkg::ST_DECODE;
			end
			i2ctqd_pkg::ST_DECODE: begin
				if (sts.is_event) begin
					state_d = sts.evt_hit ? i2ctqd_pkg::ST_EVT_REPORT : i2ctqd_pkg::ST_IDLE;
				end else begin
					state_d = (sts.sub_ok && sts.issue_now) ? i2ctqd_pkg::ST_SUB_ISSUE
					                                        : i2ctqd_pkg::ST_SUB_ACK;
				end
			end
			i2ctqd_pkg::ST_SUB_ISSUE: begin
				if (sts.out_free) state_d = i2ctqd_pkg::ST_SUB_ACK;
			end
			i2ctqd_pkg::ST_SUB_ACK: begin
				if (sts.out_free) state_d = i2ctqd_pkg::ST_IDLE;
			end
			i2ctqd_pkg::ST_EVT_REPORT: begin
				if (sts.out_free) begin
					state_d = sts.more ? i2ctqd_pkg::ST_EVT_READ : i2ctqd_pkg::ST_IDLE;
				end
			end
			// This state lets the registered store read follow the new head.
			i2ctqd_pkg::ST_EVT_READ: begin
				state_d = i2ctqd_pkg::ST_EVT_ISSUE;
			end
			i2ctqd_pkg::ST_EVT_ISSUE: begin
				if (sts.out_free) state_d = i2ctqd_pkg::ST_IDLE;
			end
			default: begin
				state_d = i2ctqd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			i2ctqd_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			i2ctqd_pkg::ST_DECODE: begin
				cmd.decode = 1'b1;
				cmd.push   = !sts.is_event && sts.sub_ok;
			end
			i2ctqd_pkg::ST_SUB_ISSUE: begin
				cmd.ld_issue_in = sts.out_free;
			end
			i2ctqd_pkg::ST_SUB_ACK: begin
				cmd.ld_ack = sts.out_free;
			end
			i2ctqd_pkg::ST_EVT_REPORT: begin
				cmd.ld_report = sts.out_free;
				cmd.pop       = sts.out_free;
			end
			i2ctqd_pkg::ST_EVT_READ: begin
			end
			i2ctqd_pkg::ST_EVT_ISSUE: begin
				cmd.ld_issue_mem = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: src/i2ctqd_datapath.sv
// Datapath: request capture, submit checks, request ring, engine phase and result register.
module i2ctqd_datapath #(
	parameter int QUEUE_DEPTH = i2ctqd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_data,
	input  logic [i2ctqd_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                                s_tuser,
	input  i2ctqd_pkg::cmd_t                    cmd,
	output i2ctqd_pkg::sts_t                    sts,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [i2ctqd_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [1:0]                          m_tuser,
	output logic                                m_tlast
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
	localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

	// Captured request.
	logic [i2ctqd_pkg::IN_DATA_W-1:0] in_data_q;
	logic                             in_mode_q;

	logic [6:0]  in_addr;
	logic [7:0]  in_count;
	logic        in_rd;
	logic        in_wr;
	logic [15:0] in_handle;
	logic [7:0]  in_tag;
	logic        in_rdone;
	logic        in_wdone;
	logic [3:0]  in_errs;

	logic                enabled_q;
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [OCC_W-1:0]    occ_q;
	i2ctqd_pkg::phase_t  phase_q;

	i2ctqd_pkg::entry_t  mem_q [QUEUE_DEPTH];
	i2ctqd_pkg::entry_t  rd_q;
	i2ctqd_pkg::entry_t  new_entry;

	logic [1:0] ack_code;
	logic [1:0] ack_q;
	logic       match;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [1:0]  out_status_q;
	logic [6:0]  out_addr_q;
	logic [7:0]  out_count_q;
	logic        out_rd_q;
	logic [15:0] out_handle_q;
	logic [7:0]  out_tag_q;
	logic [7:0]  out_xfer_q;
	logic        out_last_q;
	logic        out_load;

	assign in_addr   = in_data_q[6:0];
	assign in_count  = in_data_q[14:7];
	assign in_rd     = in_data_q[15];
	assign in_wr     = in_data_q[16];
	assign in_handle = in_data_q[32:17];
	assign in_tag    = in_data_q[40:33];
	assign in_rdone  = in_data_q[41];
	assign in_wdone  = in_data_q[42];
	assign in_errs   = in_data_q[46:43];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_data_q <= s_tdata;
			in_mode_q <= s_tuser;
		end
	end

	always_comb begin
		priority if (!enabled_q) begin
			ack_code = i2ctqd_pkg::ACK_OFF;
		end else if (in_handle == 16'd0 || in_rd == in_wr) begin
			ack_code = i2ctqd_pkg::ACK_BAD;
		end else if (occ_q == OCC_FULL) begin
			ack_code = i2ctqd_pkg::ACK_FULL;
		end else begin
			ack_code = i2ctqd_pkg::ACK_OK;
		end
	end

	assign match = (phase_q == i2ctqd_pkg::PH_RECEIVING && in_rdone) ||
	               (phase_q == i2ctqd_pkg::PH_WRITING && in_wdone);

	assign out_load = cmd.ld_issue_in | cmd.ld_issue_mem | cmd.ld_ack | cmd.ld_report;

	always_comb begin
		sts.is_event  = (in_mode_q != i2ctqd_pkg::MODE_SUBMIT);
		sts.sub_ok    = (ack_code == i2ctqd_pkg::ACK_OK);
		sts.issue_now = (occ_q == '0) && (phase_q == i2ctqd_pkg::PH_IDLE);
		sts.evt_hit   = match && (occ_q != '0);
		sts.more      = (occ_q != OCC_ONE);
		sts.out_free  = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) ack_q <= ack_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			enabled_q <= cfg_data;
		end
	end

	assign new_entry = '{addr: in_addr, count: in_count, rd: in_rd,
	                     handle: in_handle, tag: in_tag};

	// Request ring: written at the tail, read at the head with a registered read.
	always_ff @(posedge clk) begin
		if (cmd.push) mem_q[tail_q] <= new_entry;
		rd_q <= mem_q[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			phase_q <= i2ctqd_pkg::PH_IDLE;
		end else begin
			if (cmd.push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
				occ_q  <= occ_q + OCC_W'(1);
			end
			if (cmd.pop) begin
				head_q  <= (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
				occ_q   <= occ_q - OCC_W'(1);
				phase_q <= i2ctqd_pkg::PH_IDLE;
			end
			if (cmd.ld_issue_in) begin
				phase_q <= in_rd ? i2ctqd_pkg::PH_RECEIVING : i2ctqd_pkg::PH_WRITING;
			end
			if (cmd.ld_issue_mem) begin
				phase_q <= rd_q.rd ? i2ctqd_pkg::PH_RECEIVING : i2ctqd_pkg::PH_WRITING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_issue_in) begin
			out_kind_q   <= i2ctqd_pkg::KIND_ISSUE;
			out_status_q <= i2ctqd_pkg::ISSUE_STATUS;
			out_addr_q   <= in_addr;
			out_count_q  <= in_count;
			out_rd_q     <= in_rd;
			out_handle_q <= in_handle;
			out_tag_q    <= in_tag;
			out_xfer_q   <= 8'd0;
			out_last_q   <= 1'b0;
		end else if (cmd.ld_issue_mem) begin
			out_kind_q   <= i2ctqd_pkg::KIND_ISSUE;
			out_status_q <= i2ctqd_pkg::ISSUE_STATUS;
			out_addr_q   <= rd_q.addr;
			out_count_q  <= rd_q.count;
			out_rd_q     <= rd_q.rd;
			out_handle_q <= rd_q.handle;
			out_tag_q    <= rd_q.tag;
			out_xfer_q   <= 8'd0;
			out_last_q   <= 1'b1;
		end else if (cmd.ld_report) begin
			out_kind_q   <= i2ctqd_pkg::KIND_REPORT;
			out_status_q <= (in_errs != 4'd0) ? i2ctqd_pkg::RPT_ERROR : i2ctqd_pkg::RPT_DONE;
			out_addr_q   <= rd_q.addr;
			out_count_q  <= rd_q.count;
			out_rd_q     <= rd_q.rd;
			out_handle_q <= rd_q.handle;
			out_tag_q    <= rd_q.tag;
			out_xfer_q   <= (in_errs != 4'd0) ? 8'd0 : rd_q.count;
			out_last_q   <= (occ_q == OCC_ONE);
		end else if (cmd.ld_ack) begin
			out_kind_q   <= i2ctqd_pkg::KIND_ACK;
			out_status_q <= ack_q;
			out_addr_q   <= 7'd0;
			out_count_q  <= 8'd0;
			out_rd_q     <= 1'b0;
			out_handle_q <= 16'd0;
			out_tag_q    <= 8'd0;
			out_xfer_q   <= 8'd0;
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'd0, out_xfer_q, out_tag_q, out_handle_q, out_rd_q,
	                   out_count_q, out_addr_q, out_status_q};

endmodule

FILE: src/i2c_transfer_queue_dispatcher_top.sv
// Top level of the I2C transfer queue dispatcher: controller, datapath and config port.
// One request at a time: a submit loads its ack after accept, preceded by an issue result
// when it also issues; an event loads a report and then, when more entries remain, an
// issue of the next entry, or no result at all on a miss. The next request is taken once
// the last result is loaded, and a loaded result waiting on m_tready holds the next load.
// Reset clears the ring pointers, fill count, engine phase, enable and output valid.
module i2c_transfer_queue_dispatcher_top #(
	parameter int QUEUE_DEPTH = i2ctqd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// slave_address, byte_count, want_read, want_write, buffer_handle, requester_tag,
	// read_done, write_done, bus_errors, one zero pad bit
	input  logic [i2ctqd_pkg::IN_DATA_W-1:0]   s_tdata,
	// mode
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status, out_address, out_count, is_read, out_handle, out_tag, transferred,
	// six zero pad bits
	output logic [i2ctqd_pkg::OUT_DATA_W-1:0]  m_tdata,
	// kind
	output logic [1:0]                         m_tuser,
	output logic                               m_tlast
);

	i2ctqd_pkg::cmd_t cmd;
	i2ctqd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	i2ctqd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	i2ctqd_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
